// ----- rtl/gpc_pkg.sv -----
package gpc_pkg;

    // Line buffer depth and widths
    localparam int MAX_COLUMNS = 512;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int COLS_W      = $clog2(MAX_COLUMNS + 1);
    localparam int COLCNT_W    = 10;
    localparam int ROW_W       = 12;
    localparam int COUNT_W     = 25;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 12;
    localparam int CNT_W       = (COLS_W > COLCNT_W) ? COLS_W : COLCNT_W;

    localparam logic [COUNT_W:0] PATH_MOD = 26'd20170805;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 1'b1;

    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [1:0] {
        KIND_FREE     = 2'd0,
        KIND_BLOCKED  = 2'd1,
        KIND_STRAIGHT = 2'd2
    } kind_t;

    typedef struct packed {
        count_t from_left;
        count_t from_above;
    } pair_t;

    typedef struct packed {
        kind_t kind;
        pair_t counts;
    } line_word_t;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             first_row;
        logic             first_col;
        logic             last_cell;
    } pos_t;

    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        line_word_t       data;
    } lbuf_wr_t;

    typedef struct packed {
        logic  last_cell;
        logic  blocked;
        pair_t counts;
    } cell_res_t;

    function automatic count_t add_mod(count_t a, count_t b);
        logic [COUNT_W:0] s;
        logic [COUNT_W:0] d;
        s = {1'b0, a} + {1'b0, b};
        d = s - PATH_MOD;
        return (s >= PATH_MOD) ? d[COUNT_W-1:0] : s[COUNT_W-1:0];
    endfunction

endpackage

// ----- rtl/gpc_lbuf.sv -----
module gpc_lbuf
(
    input  logic                         clk,
    input  logic                         rd_en,
    input  logic [gpc_pkg::COL_W-1:0]    rd_addr,
    output gpc_pkg::line_word_t          rd_data,
    input  gpc_pkg::lbuf_wr_t            wr
);

    gpc_pkg::line_word_t mem [gpc_pkg::MAX_COLUMNS];
    gpc_pkg::line_word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/gpc_pos.sv -----
module gpc_pos
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           advance,
    input  logic [gpc_pkg::ROW_W-1:0]      row_count,
    input  logic [gpc_pkg::COLCNT_W-1:0]   column_count,
    output gpc_pkg::pos_t                  pos
);

    logic [gpc_pkg::COL_W-1:0] col_reg;
    logic [gpc_pkg::COL_W-1:0] col_next;
    logic [gpc_pkg::ROW_W-1:0] row_reg;
    logic [gpc_pkg::ROW_W-1:0] row_next;

    logic [gpc_pkg::CNT_W-1:0] cc;
    logic [gpc_pkg::CNT_W-1:0] cols;
    logic [gpc_pkg::CNT_W-1:0] col_plus;
    logic [gpc_pkg::ROW_W:0]   rows;
    logic [gpc_pkg::ROW_W:0]   row_plus;
    logic                      last_col;
    logic                      last_row;

    always_comb
    begin
        // Clamp the column count to 1..MAX_COLUMNS, the row count to at least 1
        cc = gpc_pkg::CNT_W'(column_count);
        if (cc == '0)
        begin
            cols = gpc_pkg::CNT_W'(1);
        end
        else if (cc > gpc_pkg::CNT_W'(gpc_pkg::MAX_COLUMNS))
        begin
            cols = gpc_pkg::CNT_W'(gpc_pkg::MAX_COLUMNS);
        end
        else
        begin
            cols = cc;
        end
        rows = (row_count == '0) ? (gpc_pkg::ROW_W+1)'(1) : {1'b0, row_count};

        col_plus = gpc_pkg::CNT_W'(col_reg) + gpc_pkg::CNT_W'(1);
        row_plus = {1'b0, row_reg} + (gpc_pkg::ROW_W+1)'(1);
        last_col = (col_plus >= cols);
        last_row = (row_plus >= rows);

        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (last_col && last_row)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (last_col)
            begin
                col_next = '0;
                row_next = row_plus[gpc_pkg::ROW_W-1:0];
            end
            else
            begin
                col_next = col_plus[gpc_pkg::COL_W-1:0];
            end
        end

        pos.col       = col_reg;
        pos.first_row = (row_reg == '0);
        pos.first_col = (col_reg == '0);
        pos.last_cell = last_col && last_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// ----- rtl/gpc_cell.sv -----
module gpc_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  logic [1:0]            in_kind,
    input  gpc_pkg::pos_t         in_pos,
    input  logic                  advance,
    input  gpc_pkg::line_word_t   above,
    output logic                  valid,
    output gpc_pkg::lbuf_wr_t     wr,
    output gpc_pkg::cell_res_t    res
);

    logic                s1_valid_reg;
    logic                s1_valid_next;
    gpc_pkg::kind_t      kind_reg;
    gpc_pkg::pos_t       pos_reg;
    gpc_pkg::pair_t      left_reg;
    gpc_pkg::kind_t      left_kind_reg;
    logic                top_open_reg;
    logic                top_open_next;
    logic                left_open_reg;
    logic                left_open_next;
    gpc_pkg::pair_t      cur;
    gpc_pkg::kind_t      load_kind;
    logic                blocked;

    // Count handed on by a neighbor; a no-turn neighbor keeps the straight one
    function automatic gpc_pkg::count_t pass_on(gpc_pkg::kind_t k, gpc_pkg::pair_t p,
                                                logic along_row);
        gpc_pkg::count_t r;
        case (k)
            gpc_pkg::KIND_FREE:     r = gpc_pkg::add_mod(p.from_left, p.from_above);
            gpc_pkg::KIND_STRAIGHT: r = along_row ? p.from_left : p.from_above;
            default:                r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        // The unused encoding counts as blocked
        case (in_kind)
            gpc_pkg::KIND_FREE:     load_kind = gpc_pkg::KIND_FREE;
            gpc_pkg::KIND_STRAIGHT: load_kind = gpc_pkg::KIND_STRAIGHT;
            default:                load_kind = gpc_pkg::KIND_BLOCKED;
        endcase

        blocked        = (kind_reg == gpc_pkg::KIND_BLOCKED);
        top_open_next  = top_open_reg;
        left_open_next = left_open_reg;
        cur            = '0;

        if (pos_reg.first_row && pos_reg.first_col)
        begin
            top_open_next  = top_open_reg && !blocked;
            left_open_next = left_open_reg && !blocked;
            cur.from_left  = gpc_pkg::count_t'(top_open_next);
        end
        else if (pos_reg.first_row)
        begin
            top_open_next = top_open_reg && !blocked;
            cur.from_left = gpc_pkg::count_t'(top_open_next);
        end
        else if (pos_reg.first_col)
        begin
            left_open_next = left_open_reg && !blocked;
            cur.from_above = gpc_pkg::count_t'(left_open_next);
        end
        else
        begin
            cur.from_above = pass_on(above.kind, above.counts, 1'b0);
            cur.from_left  = pass_on(left_kind_reg, left_reg, 1'b1);
        end

        s1_valid_next = load ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);

        wr.en          = advance;
        wr.addr        = pos_reg.col;
        wr.data.kind   = kind_reg;
        wr.data.counts = cur;

        res.last_cell = pos_reg.last_cell;
        res.blocked   = blocked;
        res.counts    = cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            left_reg      <= '0;
            left_kind_reg <= gpc_pkg::KIND_FREE;
            top_open_reg  <= 1'b1;
            left_open_reg <= 1'b1;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (advance)
            begin
                left_reg      <= cur;
                left_kind_reg <= kind_reg;
                // Reopen both edges for the next grid
                top_open_reg  <= pos_reg.last_cell ? 1'b1 : top_open_next;
                left_open_reg <= pos_reg.last_cell ? 1'b1 : left_open_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg <= load_kind;
            pos_reg  <= in_pos;
        end
    end

    assign valid = s1_valid_reg;

endmodule

// ----- rtl/grid_path_count_turn_limited_unit.sv -----
// The result of the last cell of a grid reaches m_tvalid through the cell stage (on the registered
//   line buffer read) and then the output register; a full output slot can hold it in the cell stage.
// Throughput: one cell per cycle when not stalled; the line buffer takes one read and one write each cycle.
//   A last cell waits in the cell stage only while the previous result is still unread.
// Reset: control, position and edge flags return to their start values at once; row_count
//   and column_count return to 1. The line buffer is not cleared: the first row fills it.
module grid_path_count_turn_limited_unit
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // configuration write channel
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [gpc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [gpc_pkg::CFG_DATA_W-1:0]        cfg_data,
    // cell item stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [7:0]                            s_tdata,  // [1:0] cell_kind
    // result item stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [31:0]                           m_tdata   // [24:0] path_count
);

    logic [gpc_pkg::ROW_W-1:0]    row_count_reg;
    logic [gpc_pkg::COLCNT_W-1:0] column_count_reg;

    logic                         accept;
    logic                         s1_valid;
    logic                         s1_adv;
    gpc_pkg::pos_t                pos;
    gpc_pkg::line_word_t          above;
    gpc_pkg::lbuf_wr_t            wr;
    gpc_pkg::cell_res_t           res;

    logic                         out_valid_reg;
    logic                         out_valid_next;
    gpc_pkg::pair_t               out_pair_reg;
    gpc_pkg::count_t              path_count;

    // Configuration: always ready; it must be written only while the block is idle, which the block does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= gpc_pkg::ROW_W'(1);
            column_count_reg <= gpc_pkg::COLCNT_W'(1);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                gpc_pkg::CFG_ROW_COUNT:
                begin
                    row_count_reg <= cfg_data[gpc_pkg::ROW_W-1:0];
                end
                gpc_pkg::CFG_COLUMN_COUNT:
                begin
                    column_count_reg <= cfg_data[gpc_pkg::COLCNT_W-1:0];
                end
                default:
                begin
                    row_count_reg <= row_count_reg;
                end
            endcase
        end
    end

    // Hold the cell stage only when it carries a result and the output slot is full
    assign s1_adv   = s1_valid && !(res.last_cell && out_valid_reg && !m_tready);
    assign s_tready = !s1_valid || s1_adv;
    assign accept   = s_tvalid && s_tready;

    // Position of the incoming cell; advance on every accepted item
    gpc_pos u_pos
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .row_count    (row_count_reg),
        .column_count (column_count_reg),
        .pos          (pos)
    );

    // Read the entry of the cell above in the same cycle the cell is accepted
    gpc_lbuf u_lbuf
    (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (pos.col),
        .rd_data (above),
        .wr      (wr)
    );

    // Combine above and left counts, write the new pair back
    gpc_cell u_cell
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept),
        .in_kind (s_tdata[1:0]),
        .in_pos  (pos),
        .advance (s1_adv),
        .above   (above),
        .valid   (s1_valid),
        .wr      (wr),
        .res     (res)
    );

    // Output slot: keep the final pair, add it on the way out
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (s1_adv && res.last_cell)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && res.last_cell)
        begin
            // A blocked last cell gives no paths
            out_pair_reg <= res.blocked ? '0 : res.counts;
        end
    end

    assign path_count = gpc_pkg::add_mod(out_pair_reg.from_left, out_pair_reg.from_above);
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {7'd0, path_count};

    // The cell stage stalls only behind a full output slot
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid && !s1_adv) |-> (res.last_cell && out_valid_reg && !m_tready))
        else $error("cell stage stalled without a full output slot");

    // After the last cell of a grid the next cell is the top-left one
    a_grid_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && pos.last_cell) |=> (pos.first_row && pos.first_col))
        else $error("position did not return to the grid origin");

    // A result enters the output slot only from a last cell
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_adv && res.last_cell))
        else $error("result produced without a last cell");

    // A waiting result is not dropped before it is taken
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_tready) |=> (out_valid_reg && $stable(out_pair_reg)))
        else $error("pending result lost or changed");

endmodule
